### rtl/core/char_lcd_nibble_writer_unit_macros.svh
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit_macros: assertion helpers
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_MACROS_SVH

// Property that holds in the same cycle
`define CLNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property checked in the cycle after the antecedent
`define CLNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, codes and the init strobe table of the LCD nibble writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 8;
  localparam int COLUMN_W = 6;
  localparam int NIBBLE_W = 4;
  localparam int BEFORE_W = 16;
  localparam int AFTER_W  = 17;
  localparam int STEP_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int ENABLE_W   = 8;
  localparam int GAP_W      = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP  = 1'b1;
  localparam logic [ENABLE_W-1:0]  ENABLE_RESET    = 8'd2;
  localparam logic [GAP_W-1:0]     GAP_RESET       = 10'd40;

  // Decoupling queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Waits in microseconds
  localparam logic [BEFORE_W-1:0] POWER_ON_WAIT = 16'd50000;
  localparam logic [AFTER_W-1:0]  SHORT_WAIT    = 17'd5000;
  localparam logic [AFTER_W-1:0]  LONG_WAIT     = 17'd100000;

  // Command bytes
  localparam logic [VALUE_W-1:0] CMD_CLEAR    = 8'h01;
  localparam logic [VALUE_W-1:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0]         ROW1_OFFSET  = 7'h40;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_CURSOR = 3'd4
  } op_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic               is_init;
    logic               is_clear;
    logic               rs;
    logic [VALUE_W-1:0] data;
  } desc_t;

  typedef struct packed {
    logic [NIBBLE_W-1:0] nibble;
    logic [BEFORE_W-1:0] pre_wait;
    logic [AFTER_W-1:0]  after;
  } init_step_t;

  // Init sequence: wake-up 3,3,3,2 then 0x28, 0x0C, 0x06, clear
  function automatic init_step_t init_step(input logic [STEP_W-1:0] idx);
    init_step_t s;
    s.nibble   = 4'h0;
    s.pre_wait = '0;
    s.after    = '0;
    case (idx)
      4'd0: begin
        s.nibble   = 4'h3;
        s.pre_wait = POWER_ON_WAIT;
        s.after    = SHORT_WAIT;
      end
      4'd1: begin
        s.nibble = 4'h3;
        s.after  = LONG_WAIT;
      end
      4'd2: begin
        s.nibble = 4'h3;
        s.after  = LONG_WAIT;
      end
      4'd3: begin
        s.nibble = 4'h2;
        s.after  = LONG_WAIT;
      end
      4'd4:  s.nibble = 4'h2;
      4'd5:  s.nibble = 4'h8;
      4'd6:  s.nibble = 4'h0;
      4'd7:  s.nibble = 4'hC;
      4'd8:  s.nibble = 4'h0;
      4'd9:  s.nibble = 4'h6;
      4'd10: s.nibble = 4'h0;
      4'd11: begin
        s.nibble = 4'h1;
        s.after  = SHORT_WAIT;
      end
      default: s.nibble = 4'h0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/clnw_req_if.sv
// ----------------------------------------------------------------------------
// clnw_req_if
// Request channel: op and operands with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface clnw_req_if;
  logic                           valid;
  logic                           ready;
  logic [clnw_pkg::OP_W-1:0]      op;
  logic [clnw_pkg::VALUE_W-1:0]   value;
  logic [clnw_pkg::COLUMN_W-1:0]  column;
  logic                           row;

  modport source (output valid, op, value, column, row, input ready);
  modport sink   (input valid, op, value, column, row, output ready);
endinterface

`default_nettype wire

### rtl/core/clnw_strb_if.sv
// ----------------------------------------------------------------------------
// clnw_strb_if
// Strobe channel: one nibble strobe with its waits, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface clnw_strb_if;
  logic                           valid;
  logic                           ready;
  logic                           reg_select;
  logic [clnw_pkg::NIBBLE_W-1:0]  nibble;
  logic [clnw_pkg::BEFORE_W-1:0]  wait_before_us;
  logic [clnw_pkg::AFTER_W-1:0]   wait_after_us;
  logic                           last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/clnw_cfg_if.sv
// ----------------------------------------------------------------------------
// clnw_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface clnw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [clnw_pkg::CFG_IDX_W-1:0]   index;
  logic [clnw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Accepts requests, drops unknown ops and turns the rest into descriptors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clnw_front (
  clnw_req_if.sink               req,
  input  wire logic              q_ready,
  output clnw_pkg::desc_t        q_desc,
  output logic                   q_push
);

  logic        known_op;
  logic [6:0]  cursor_addr;

  // Cursor address: column plus 0x40 on row 1, fits in 7 bits
  assign cursor_addr = {1'b0, req.column} + (req.row ? clnw_pkg::ROW1_OFFSET : 7'h00);

  // Classify the request
  always_comb begin
    known_op        = 1'b1;
    q_desc.is_init  = 1'b0;
    q_desc.is_clear = 1'b0;
    q_desc.rs       = 1'b0;
    q_desc.data     = req.value;
    case (req.op)
      clnw_pkg::OP_INIT: begin
        q_desc.is_init = 1'b1;
      end
      clnw_pkg::OP_CMD: begin
        q_desc.rs = 1'b0;
      end
      clnw_pkg::OP_DATA: begin
        q_desc.rs = 1'b1;
      end
      clnw_pkg::OP_CLEAR: begin
        q_desc.is_clear = 1'b1;
        q_desc.data     = clnw_pkg::CMD_CLEAR;
      end
      clnw_pkg::OP_CURSOR: begin
        q_desc.data = clnw_pkg::CMD_SET_DDRAM | {1'b0, cursor_addr};
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // Unknown ops are taken and dropped
  assign req.ready = q_ready;
  assign q_push    = req.valid && q_ready && known_op;

endmodule

`default_nettype wire

### rtl/core/clnw_queue.sv
// ----------------------------------------------------------------------------
// clnw_queue
// Short descriptor FIFO between the front and the strobe sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clnw_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  clnw_pkg::desc_t       push_desc,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  head_valid,
  output clnw_pkg::desc_t       head_desc
);

  clnw_pkg::desc_t                  mem_r [clnw_pkg::QDEPTH];
  logic [clnw_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [clnw_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [clnw_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign not_full   = count_r != clnw_pkg::QCNT_W'(clnw_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == clnw_pkg::QPTR_W'(clnw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == clnw_pkg::QPTR_W'(clnw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### rtl/core/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Strobe sequencer: walks a descriptor and emits one strobe per cycle while strb is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clnw_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  clnw_pkg::desc_t       head_desc,
  output logic                  pop,
  clnw_strb_if.source           strb
);

  logic [clnw_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           rs_r;
  logic [clnw_pkg::NIBBLE_W-1:0]  nibble_r;
  logic [clnw_pkg::BEFORE_W-1:0]  before_r;
  logic [clnw_pkg::AFTER_W-1:0]   after_r;
  logic                           last_r;

  clnw_pkg::init_step_t           init_s;
  logic [clnw_pkg::NIBBLE_W-1:0]  cur_nibble;
  logic [clnw_pkg::BEFORE_W-1:0]  cur_before;
  logic [clnw_pkg::AFTER_W-1:0]   cur_after;
  logic                           cur_last;
  logic                           load;

  assign init_s = clnw_pkg::init_step(step_r);

  // Strobe fields for the current step
  always_comb begin
    if (head_desc.is_init) begin
      cur_nibble = init_s.nibble;
      cur_before = init_s.pre_wait;
      cur_after  = init_s.after;
      cur_last   = step_r == clnw_pkg::INIT_LAST_STEP;
    end else begin
      // high nibble first
      cur_nibble = step_r[0] ? head_desc.data[3:0] : head_desc.data[7:4];
      cur_before = '0;
      cur_after  = (head_desc.is_clear && step_r[0]) ? clnw_pkg::SHORT_WAIT : '0;
      cur_last   = step_r[0];
    end
  end

  // Output register loads when empty or being taken
  assign load = head_valid && (!out_valid_r || strb.ready);
  assign pop  = load && cur_last;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = cur_last ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (strb.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Strobe payload
  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= head_desc.rs;
      nibble_r <= cur_nibble;
      before_r <= cur_before;
      after_r  <= cur_after;
      last_r   <= cur_last;
    end
  end

  assign strb.valid          = out_valid_r;
  assign strb.reg_select     = rs_r;
  assign strb.nibble         = nibble_r;
  assign strb.wait_before_us = before_r;
  assign strb.wait_after_us  = after_r;
  assign strb.last           = last_r;

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit: character-LCD 4-bit bus writer, top level
// First strobe of a request passes through the queue, then the sequencer's output register.
// One strobe per cycle from the sequencer while out_strb is ready: 2 strobes per byte request, 12 per init.
// Reset empties the queue and sets enable_high_us to 2, nibble_gap_us to 40.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_writer_unit_macros.svh"

module char_lcd_nibble_writer_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  clnw_req_if.sink      in_req,
  clnw_strb_if.source   out_strb,
  clnw_cfg_if.sink      cfg_wr
);

  clnw_pkg::desc_t                   front_desc;
  logic                              front_push;
  logic                              q_not_full;
  logic                              q_head_valid;
  clnw_pkg::desc_t                   q_head_desc;
  logic                              back_pop;
  logic                              cfg_fire;
  logic [clnw_pkg::ENABLE_W-1:0]     enable_high_r, enable_high_nxt;
  logic [clnw_pkg::GAP_W-1:0]        nibble_gap_r, nibble_gap_nxt;

  // Front: accept and classify
  clnw_front u_front (
    .req     (in_req),
    .q_ready (q_not_full),
    .q_desc  (front_desc),
    .q_push  (front_push)
  );

  // Queue between front and back
  clnw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_desc  (front_desc),
    .not_full   (q_not_full),
    .pop        (back_pop),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc)
  );

  // Back: strobe sequencer
  clnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc),
    .pop        (back_pop),
    .strb       (out_strb)
  );

  // Timing registers kept for the bus driver
  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;

  always_comb begin
    enable_high_nxt = enable_high_r;
    nibble_gap_nxt  = nibble_gap_r;
    if (cfg_fire) begin
      case (cfg_wr.index)
        clnw_pkg::CFG_ENABLE_HIGH: enable_high_nxt = cfg_wr.data[clnw_pkg::ENABLE_W-1:0];
        clnw_pkg::CFG_NIBBLE_GAP:  nibble_gap_nxt  = cfg_wr.data[clnw_pkg::GAP_W-1:0];
        default: begin
          enable_high_nxt = enable_high_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_high_r <= clnw_pkg::ENABLE_RESET;
      nibble_gap_r  <= clnw_pkg::GAP_RESET;
    end else begin
      enable_high_r <= enable_high_nxt;
      nibble_gap_r  <= nibble_gap_nxt;
    end
  end

  // Checks
  `CLNW_ASSERT_NEXT(a_cfg_enable, cfg_fire && cfg_wr.index == clnw_pkg::CFG_ENABLE_HIGH, enable_high_r == $past(cfg_wr.data[clnw_pkg::ENABLE_W-1:0]), "enable_high_us write lost")
  `CLNW_ASSERT_NEXT(a_cfg_gap, cfg_fire && cfg_wr.index == clnw_pkg::CFG_NIBBLE_GAP, nibble_gap_r == $past(cfg_wr.data), "nibble_gap_us write lost")
  `CLNW_ASSERT_NOW(a_unknown_drop, in_req.valid && in_req.op > 3'(clnw_pkg::OP_CURSOR), !front_push, "unknown op queued")
  `CLNW_ASSERT_NOW(a_power_on, out_strb.valid && out_strb.wait_before_us != '0, !out_strb.last && out_strb.nibble == 4'h3 && !out_strb.reg_select, "power-on wait on wrong strobe")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: character-LCD nibble writer
// Drives LCD requests (init, command, data, clear, set cursor, unknown ops)
// into the writer and checks every nibble strobe against a strobe predictor.
// Runs directed corner requests, then random traffic with text lines, under
// changing bus timing, idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import clnw_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 250;

  localparam logic [OP_W-1:0]     OP_CODE_TOP  = 3'd7;
  localparam logic                RS_CMD       = 1'b0;
  localparam logic                RS_DATA      = 1'b1;
  localparam logic [NIBBLE_W-1:0] WAKE_NIBBLE  = 4'h3;
  localparam logic [NIBBLE_W-1:0] BUS4_NIBBLE  = 4'h2;
  localparam logic [VALUE_W-1:0]  FUNCTION_SET = 8'h28;
  localparam logic [VALUE_W-1:0]  DISPLAY_ON   = 8'h0C;
  localparam logic [VALUE_W-1:0]  ENTRY_MODE   = 8'h06;

  typedef struct packed {
    logic                rs;
    logic [NIBBLE_W-1:0] nibble;
    logic [BEFORE_W-1:0] pre_wait;
    logic [AFTER_W-1:0]  after;
    logic                last;
  } strobe_t;

  logic clk;
  logic rst_n;

  clnw_req_if  in_req();
  clnw_strb_if out_strb();
  clnw_cfg_if  cfg_wr();

  char_lcd_nibble_writer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_strb (out_strb),
    .cfg_wr   (cfg_wr)
  );

  strobe_t strobes_due[$];
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Strobe predictor
  function automatic void push_strobe(logic rs, logic [NIBBLE_W-1:0] nib,
                                      logic [BEFORE_W-1:0] pre_wait,
                                      logic [AFTER_W-1:0] after);
    strobe_t s;
    s.rs       = rs;
    s.nibble   = nib;
    s.pre_wait = pre_wait;
    s.after    = after;
    s.last     = 1'b0;
    strobes_due.push_back(s);
  endfunction

  // High nibble first
  function automatic void push_byte(logic rs, logic [VALUE_W-1:0] b);
    push_strobe(rs, b[7:4], '0, '0);
    push_strobe(rs, b[3:0], '0, '0);
  endfunction

  // Clear display, plus the short settle on its second nibble
  function automatic void push_clear();
    strobe_t s;
    push_byte(RS_CMD, CMD_CLEAR);
    s = strobes_due.pop_back();
    s.after = SHORT_WAIT;
    strobes_due.push_back(s);
  endfunction

  function automatic void expect_strobes(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                         logic [COLUMN_W-1:0] column, logic row);
    int      first;
    logic [6:0] addr;
    strobe_t s;
    first = strobes_due.size();
    case (op)
      OP_INIT: begin
        push_strobe(RS_CMD, WAKE_NIBBLE, POWER_ON_WAIT, SHORT_WAIT);
        push_strobe(RS_CMD, WAKE_NIBBLE, '0, LONG_WAIT);
        push_strobe(RS_CMD, WAKE_NIBBLE, '0, LONG_WAIT);
        push_strobe(RS_CMD, BUS4_NIBBLE, '0, LONG_WAIT);
        push_byte(RS_CMD, FUNCTION_SET);
        push_byte(RS_CMD, DISPLAY_ON);
        push_byte(RS_CMD, ENTRY_MODE);
        push_clear();
      end
      OP_CMD:   push_byte(RS_CMD, value);
      OP_DATA:  push_byte(RS_DATA, value);
      OP_CLEAR: push_clear();
      OP_CURSOR: begin
        // 7-bit DDRAM address, row 1 starts at 0x40
        addr = {1'b0, column} + (row ? ROW1_OFFSET : 7'h00);
        push_byte(RS_CMD, CMD_SET_DDRAM | {1'b0, addr});
      end
      default: ;  // unknown op: dropped without output
    endcase
    if (strobes_due.size() > first) begin
      s = strobes_due.pop_back();
      s.last = 1'b1;
      strobes_due.push_back(s);
    end
  endfunction

  // Strobe sink: random stalls, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started  <= hold_requests;
      hold_left      <= HOLD_CYCLES;
      out_strb.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_strb.ready <= 1'b0;
    end else begin
      out_strb.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Strobe checker
  always @(posedge clk) begin
    strobe_t want;
    if (rst_n && out_strb.valid && out_strb.ready) begin
      if (strobes_due.size() == 0) begin
        $error("strobe with none expected: rs %0d nibble %0h last %0d",
               out_strb.reg_select, out_strb.nibble, out_strb.last);
        mismatches++;
      end else begin
        want = strobes_due.pop_front();
        if (out_strb.reg_select !== want.rs) begin
          $error("reg_select: expected %0d, got %0d", want.rs, out_strb.reg_select);
          mismatches++;
        end
        if (out_strb.nibble !== want.nibble) begin
          $error("nibble: expected %0h, got %0h", want.nibble, out_strb.nibble);
          mismatches++;
        end
        if (out_strb.wait_before_us !== want.pre_wait) begin
          $error("wait_before_us: expected %0d, got %0d", want.pre_wait,
                 out_strb.wait_before_us);
          mismatches++;
        end
        if (out_strb.wait_after_us !== want.after) begin
          $error("wait_after_us: expected %0d, got %0d", want.after,
                 out_strb.wait_after_us);
          mismatches++;
        end
        if (out_strb.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_strb.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_strb.valid && out_strb.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request, with random idle cycles ahead of it
  task automatic send_req(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                          input logic [COLUMN_W-1:0] column, input logic row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid  <= 1'b1;
    in_req.op     <= op;
    in_req.value  <= value;
    in_req.column <= column;
    in_req.row    <= row;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    expect_strobes(op, value, column, row);
  endtask

  // Random operand fields
  function automatic logic [VALUE_W-1:0] rnd_value();
    return VALUE_W'($urandom_range(255));
  endfunction

  function automatic logic [COLUMN_W-1:0] rnd_column();
    return COLUMN_W'($urandom_range(63));
  endfunction

  function automatic logic rnd_row();
    return 1'($urandom_range(1));
  endfunction

  // Hold new requests until every expected strobe is out, then let it settle
  task automatic drain();
    in_req.valid <= 1'b0;
    while (strobes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers valid once its writes are done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
  endtask

  // Bus timing only paces the LCD bus, no strobe field depends on it
  task automatic reprogram_timing(input logic [ENABLE_W-1:0] enable_us,
                                  input logic [GAP_W-1:0] gap_us);
    drain();
    write_reg(CFG_ENABLE_HIGH, CFG_DATA_W'(enable_us));
    write_reg(CFG_NIBBLE_GAP, CFG_DATA_W'(gap_us));
    cfg_wr.valid <= 1'b0;
  endtask

  // Field extremes, every op, unused fields, cursor corners, unknown ops
  task automatic test_directed();
    send_req(OP_INIT, rnd_value(), rnd_column(), rnd_row());
    send_req(OP_CMD, 8'h00, 6'd0, 1'b0);
    send_req(OP_CMD, 8'hFF, 6'd63, 1'b1);
    send_req(OP_DATA, 8'h00, 6'd63, 1'b1);
    send_req(OP_DATA, 8'hFF, 6'd0, 1'b0);
    send_req(OP_DATA, 8'h5A, rnd_column(), rnd_row());
    send_req(OP_CLEAR, 8'hFF, 6'd63, 1'b1);
    send_req(OP_CLEAR, 8'h00, 6'd0, 1'b0);
    send_req(OP_CURSOR, 8'hFF, 6'd0, 1'b0);
    send_req(OP_CURSOR, 8'h00, 6'd63, 1'b0);
    send_req(OP_CURSOR, 8'hA5, 6'd0, 1'b1);
    send_req(OP_CURSOR, 8'h3C, 6'd63, 1'b1);
    send_req(OP_CURSOR, rnd_value(), 6'd42, 1'b1);
    send_req(OP_CURSOR + 3'd1, 8'hFF, 6'd63, 1'b1);
    send_req(OP_CURSOR + 3'd2, 8'h00, 6'd0, 1'b0);
    send_req(OP_CODE_TOP, rnd_value(), rnd_column(), rnd_row());
    send_req(OP_INIT, 8'h00, 6'd0, 1'b0);
    send_req(OP_DATA, 8'h41, 6'd0, 1'b0);
  endtask

  // Mostly text lines (cursor then characters), mixed with single requests
  task automatic test_random_mix(input int n_items);
    int done;
    int len;
    int pick;
    logic [OP_W-1:0] op;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(1, 10);
        send_req(OP_CURSOR, rnd_value(), rnd_column(), rnd_row());
        repeat (len)
          send_req(OP_DATA, VALUE_W'($urandom_range(8'h20, 8'h7E)), rnd_column(),
                   rnd_row());
        done += len + 1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 4)       op = OP_INIT;
        else if (pick < 36) op = OP_DATA;
        else if (pick < 60) op = OP_CMD;
        else if (pick < 70) op = OP_CLEAR;
        else if (pick < 92) op = OP_CURSOR;
        else                op = OP_W'($urandom_range(OP_CURSOR + 1, OP_CODE_TOP));
        send_req(op, rnd_value(), rnd_column(), rnd_row());
        if (op <= OP_CURSOR) done++;
      end
    end
  endtask

  // Output held off for a long stretch while requests keep coming
  task automatic test_output_holdoff();
    hold_requests <= hold_requests + 1;
    send_req(OP_INIT, rnd_value(), rnd_column(), rnd_row());
    repeat (12)
      send_req(OP_DATA, rnd_value(), rnd_column(), rnd_row());
    send_req(OP_CLEAR, rnd_value(), rnd_column(), rnd_row());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_req.valid   = 1'b0;
    in_req.op      = OP_INIT;
    in_req.value   = '0;
    in_req.column  = '0;
    in_req.row     = 1'b0;
    cfg_wr.valid   = 1'b0;
    cfg_wr.index   = CFG_ENABLE_HIGH;
    cfg_wr.data    = '0;
    out_strb.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow sender, slower receiver
    send_idle_pct = 36;
    recv_idle_pct = 55;
    reprogram_timing(ENABLE_W'($urandom_range(1, 255)), GAP_W'($urandom_range(1, 1000)));
    test_directed();
    test_random_mix(120);

    // Roles swapped, shortest bus timing
    reprogram_timing(8'd1, 10'd1);
    send_idle_pct = 55;
    recv_idle_pct = 36;
    test_random_mix(120);

    // No idling, longest bus timing
    reprogram_timing(8'd255, 10'd1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(100);

    // Back to reset timing for the hold-off and a last stretch
    reprogram_timing(ENABLE_RESET, GAP_RESET);
    test_output_holdoff();
    test_random_mix(20);

    drain();
    if (mismatches == 0 && strobes_due.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/clnw_pkg.sv
rtl/core/clnw_req_if.sv
rtl/core/clnw_strb_if.sv
rtl/core/clnw_cfg_if.sv
rtl/core/clnw_front.sv
rtl/core/clnw_queue.sv
rtl/core/clnw_back.sv
rtl/core/char_lcd_nibble_writer_unit.sv
tb/testbench.sv
